FILE: hw/rtl/tlsp_pkg.sv
package tlsp_pkg;

    // field widths of one result beat
    localparam int KIND_W    = 4;
    localparam int SPACING_W = 10;
    localparam int FLAGS_W   = 7;
    localparam int ROW_W     = 8;
    localparam int COL_W     = 8;
    localparam int ERR_W     = 3;
    localparam int POS_W     = 12;

    localparam logic [SPACING_W-1:0] SPACING_MAX = 10'd1023;

    // cell kinds
    localparam logic [KIND_W-1:0] KIND_CENTRE = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RIGHT  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LEFT   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd3;
    localparam logic [KIND_W-1:0] KIND_SPAN   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LONG   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_DOWN   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_HORIZ  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_DHORIZ = 4'd8;
    localparam logic [KIND_W-1:0] KIND_VERT   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_DVERT  = 4'd10;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_KEY      = 3'd1;
    localparam logic [ERR_W-1:0] ERR_SPACERS  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_SPACING  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_MODIFIER = 3'd4;
    localparam logic [ERR_W-1:0] ERR_FONT     = 3'd5;

    // modifier flag bit positions
    localparam int FLAG_Z      = 0;
    localparam int FLAG_U      = 1;
    localparam int FLAG_E      = 2;
    localparam int FLAG_T      = 3;
    localparam int FLAG_D      = 4;
    localparam int FLAG_BOLD   = 5;
    localparam int FLAG_ITALIC = 6;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_CASE   = 8'h20;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_Z      = 8'h7A;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_F      = 8'h66;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } t_key;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + CH_CASE;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic t_key key_lookup(input logic [7:0] lc);
        t_key k;
        k.hit  = 1'b1;
        k.kind = KIND_CENTRE;
        case (lc)
            CH_C:     k.kind = KIND_CENTRE;
            CH_R:     k.kind = KIND_RIGHT;
            CH_L:     k.kind = KIND_LEFT;
            CH_N:     k.kind = KIND_NUMBER;
            CH_S:     k.kind = KIND_SPAN;
            CH_A:     k.kind = KIND_LONG;
            CH_CARET: k.kind = KIND_DOWN;
            CH_MINUS: k.kind = KIND_HORIZ;
            CH_UNDER: k.kind = KIND_HORIZ;
            CH_EQUAL: k.kind = KIND_DHORIZ;
            CH_BAR:   k.kind = KIND_VERT;
            default:  k.hit  = 1'b0;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/table_layout_spec_parser.sv
// path: a character beat accepted on the slave side waits in the input register, and its
//   record (if any) is registered in the output register that drives the master side
// throughput: one character per cycle while the master side keeps taking beats
// reset: i_rst_n low at a clock edge clears the parser to the start of the first row,
//   drops any held character and any waiting record
module table_layout_spec_parser #(
    parameter int MAX_SPACING_DIGITS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: one layout character per beat
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    // master side: one record per beat
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [3:0] cell_kind, [13:4] spacing, [20:14] modifier_flags,
                                     // [28:21] row_index, [36:29] column_index,
                                     // [39:37] error_code, [51:40] error_position, [55:52] zero
    output logic        o_m_tuser,   // [0] cell_valid
    output logic        o_m_tlast    // layout_done
);

    // digit counter must hold the limit itself; the accumulated value holds the
    // largest number of the allowed digit count, and at least the spacing range
    localparam int CW = $clog2(MAX_SPACING_DIGITS + 1);
    localparam int DW = $clog2(10 ** MAX_SPACING_DIGITS);
    localparam int VW = (DW > tlsp_pkg::SPACING_W) ? DW : tlsp_pkg::SPACING_W;

    typedef enum logic [2:0] {
        PH_SKIP,     // blanks between cells, waiting for a key
        PH_BAR,      // single bar seen, checking for a second one
        PH_MODS,     // inside a cell, reading modifiers
        PH_DIGITS,   // inside a spacing number
        PH_FONT      // after f, waiting for the font letter
    } t_phase;

    // input stage
    logic                            r_in_vld;
    logic [7:0]                      r_ch;

    // parser state
    t_phase                          r_phase,     n_phase;
    logic [tlsp_pkg::KIND_W-1:0]     r_kind,      n_kind;
    logic [tlsp_pkg::FLAGS_W-1:0]    r_flags,     n_flags;
    logic [tlsp_pkg::SPACING_W-1:0]  r_spacing,   n_spacing;
    logic [CW-1:0]                   r_dcount,    n_dcount;
    logic [VW-1:0]                   r_dval,      n_dval;
    logic [tlsp_pkg::POS_W-1:0]      r_dstart,    n_dstart;
    logic                            r_prev_bar,  n_prev_bar;
    logic [tlsp_pkg::ROW_W-1:0]      r_row,       n_row;
    logic [tlsp_pkg::COL_W-1:0]      r_col,       n_col;
    logic [tlsp_pkg::COL_W-1:0]      r_cell_col,  n_cell_col;
    logic [tlsp_pkg::POS_W-1:0]      r_pos,       n_pos;
    logic [tlsp_pkg::POS_W-1:0]      r_bar_pos,   n_bar_pos;
    logic                            r_aborted,   n_aborted;
    logic                            r_done,      n_done;
    logic                            r_at_start,  n_at_start;
    logic                            r_have_row,  n_have_row;

    // output register
    logic                            r_out_vld;
    logic                            r_o_valid;
    logic [tlsp_pkg::KIND_W-1:0]     r_o_kind;
    logic [tlsp_pkg::SPACING_W-1:0]  r_o_spacing;
    logic [tlsp_pkg::FLAGS_W-1:0]    r_o_flags;
    logic [tlsp_pkg::ROW_W-1:0]      r_o_row;
    logic [tlsp_pkg::COL_W-1:0]      r_o_col;
    logic [tlsp_pkg::ERR_W-1:0]      r_o_err;
    logic [tlsp_pkg::POS_W-1:0]      r_o_epos;
    logic                            r_o_done;

    // record built from the held character
    logic                            e_present;
    logic                            e_valid;
    logic [tlsp_pkg::KIND_W-1:0]     e_kind;
    logic [tlsp_pkg::SPACING_W-1:0]  e_spacing;
    logic [tlsp_pkg::FLAGS_W-1:0]    e_flags;
    logic [tlsp_pkg::ROW_W-1:0]      e_row;
    logic [tlsp_pkg::COL_W-1:0]      e_col;
    logic [tlsp_pkg::ERR_W-1:0]      e_err;
    logic [tlsp_pkg::POS_W-1:0]      e_epos;
    logic                            e_done;

    logic                            w_adv;

    // the held character moves on whenever the output register has room, so a
    // stall on the master side backs up by one beat only
    assign w_adv      = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || w_adv;

    always_comb begin
        logic [7:0]          c;
        logic [7:0]          lc;
        logic                is_dig;
        logic                dbl;
        logic                run_mods;
        logic                run_skip;
        tlsp_pkg::t_key      key;
        logic [VW+3:0]       acc;

        c        = r_ch;
        lc       = tlsp_pkg::to_lower(r_ch);
        is_dig   = (c >= tlsp_pkg::CH_DIG0) && (c <= tlsp_pkg::CH_DIG9);
        dbl      = (c == tlsp_pkg::CH_BAR);
        key      = tlsp_pkg::key_lookup(lc);
        acc      = ({4'b0, r_dval} << 3) + ({4'b0, r_dval} << 1) + (VW+4)'(c[3:0]);
        run_mods = 1'b0;
        run_skip = 1'b0;

        n_phase    = r_phase;
        n_kind     = r_kind;
        n_flags    = r_flags;
        n_spacing  = r_spacing;
        n_dcount   = r_dcount;
        n_dval     = r_dval;
        n_dstart   = r_dstart;
        n_prev_bar = r_prev_bar;
        n_row      = r_row;
        n_col      = r_col;
        n_cell_col = r_cell_col;
        n_pos      = r_pos;
        n_bar_pos  = r_bar_pos;
        n_aborted  = r_aborted;
        n_done     = r_done;
        n_at_start = r_at_start;
        n_have_row = r_have_row;

        e_present = 1'b0;
        e_valid   = 1'b0;
        e_kind    = '0;
        e_spacing = '0;
        e_flags   = '0;
        e_row     = '0;
        e_col     = '0;
        e_err     = tlsp_pkg::ERR_NONE;
        e_epos    = '0;
        e_done    = 1'b0;

        if (w_adv && !r_done) begin
            if (r_aborted) begin
                // rest of the line is dropped, only the position is tracked
                if (c == tlsp_pkg::CH_NUL) begin
                    n_at_start = 1'b1;
                    n_aborted  = 1'b0;
                    n_pos      = '0;
                    n_phase    = PH_SKIP;
                    n_dcount   = '0;
                    n_dval     = '0;
                end else if (r_pos != '1) begin
                    n_pos = r_pos + 1'b1;
                end
            end else begin
                // every line opens a row
                if (r_at_start) begin
                    if (n_have_row && n_row != '1) begin
                        n_row = n_row + 1'b1;
                    end
                    n_have_row = 1'b1;
                    n_col      = '0;
                    n_prev_bar = 1'b0;
                    n_at_start = 1'b0;
                end

                case (r_phase)
                    PH_SKIP: begin
                        run_skip = 1'b1;
                    end
                    PH_BAR: begin
                        if (n_prev_bar) begin
                            e_present = 1'b1;
                            e_row     = n_row;
                            e_col     = n_col;
                            e_err     = tlsp_pkg::ERR_SPACERS;
                            e_epos    = dbl ? r_pos : r_bar_pos;
                            n_aborted = 1'b1;
                            n_phase   = PH_SKIP;
                        end else begin
                            n_kind     = dbl ? tlsp_pkg::KIND_DVERT : tlsp_pkg::KIND_VERT;
                            n_flags    = '0;
                            n_spacing  = '0;
                            n_dcount   = '0;
                            n_dval     = '0;
                            n_cell_col = n_col;
                            if (n_col != '1) begin
                                n_col = n_col + 1'b1;
                            end
                            n_prev_bar = 1'b1;
                            n_phase    = PH_MODS;
                            // a lone bar hands this character on to the modifiers
                            run_mods   = !dbl;
                        end
                    end
                    PH_MODS: begin
                        run_mods = 1'b1;
                    end
                    PH_DIGITS: begin
                        if (is_dig) begin
                            if (r_dcount == CW'(MAX_SPACING_DIGITS)) begin
                                // too many digits: cell keeps its earlier spacing
                                e_present = 1'b1;
                                e_valid   = 1'b1;
                                e_kind    = r_kind;
                                e_spacing = r_spacing;
                                e_flags   = r_flags;
                                e_row     = n_row;
                                e_col     = r_cell_col;
                                e_err     = tlsp_pkg::ERR_SPACING;
                                e_epos    = r_dstart;
                                n_aborted = 1'b1;
                                n_phase   = PH_SKIP;
                            end else begin
                                n_dcount = r_dcount + 1'b1;
                                n_dval   = acc[VW-1:0];
                            end
                        end else begin
                            if (r_dval > VW'(tlsp_pkg::SPACING_MAX)) begin
                                n_spacing = tlsp_pkg::SPACING_MAX;
                            end else begin
                                n_spacing = r_dval[tlsp_pkg::SPACING_W-1:0];
                            end
                            n_dcount = '0;
                            n_dval   = '0;
                            n_phase  = PH_MODS;
                            run_mods = 1'b1;
                        end
                    end
                    PH_FONT: begin
                        if (lc == tlsp_pkg::CH_B) begin
                            n_flags[tlsp_pkg::FLAG_BOLD] = 1'b1;
                            n_phase = PH_MODS;
                        end else if (lc == tlsp_pkg::CH_I) begin
                            n_flags[tlsp_pkg::FLAG_ITALIC] = 1'b1;
                            n_phase = PH_MODS;
                        end else begin
                            e_present = 1'b1;
                            e_valid   = 1'b1;
                            e_kind    = r_kind;
                            e_spacing = r_spacing;
                            e_flags   = r_flags;
                            e_row     = n_row;
                            e_col     = r_cell_col;
                            e_err     = tlsp_pkg::ERR_FONT;
                            e_epos    = r_pos;
                            n_aborted = 1'b1;
                            n_phase   = PH_SKIP;
                        end
                    end
                    default: begin
                        n_phase = PH_SKIP;
                    end
                endcase

                if (run_mods) begin
                    if (c == tlsp_pkg::CH_NUL || c == tlsp_pkg::CH_SPACE ||
                        c == tlsp_pkg::CH_TAB || c == tlsp_pkg::CH_COMMA ||
                        c == tlsp_pkg::CH_PERIOD) begin
                        // terminator closes the cell, then acts as a separator
                        e_present = 1'b1;
                        e_valid   = 1'b1;
                        e_kind    = n_kind;
                        e_spacing = n_spacing;
                        e_flags   = n_flags;
                        e_row     = n_row;
                        e_col     = n_cell_col;
                        n_phase   = PH_SKIP;
                        run_skip  = 1'b1;
                    end else if (is_dig) begin
                        n_dstart = r_pos;
                        n_dcount = CW'(1);
                        n_dval   = VW'(c[3:0]);
                        n_phase  = PH_DIGITS;
                    end else if (lc == tlsp_pkg::CH_Z) begin
                        n_flags[tlsp_pkg::FLAG_Z] = 1'b1;
                    end else if (lc == tlsp_pkg::CH_U) begin
                        n_flags[tlsp_pkg::FLAG_U] = 1'b1;
                    end else if (lc == tlsp_pkg::CH_E) begin
                        n_flags[tlsp_pkg::FLAG_E] = 1'b1;
                    end else if (lc == tlsp_pkg::CH_T) begin
                        n_flags[tlsp_pkg::FLAG_T] = 1'b1;
                    end else if (lc == tlsp_pkg::CH_D) begin
                        n_flags[tlsp_pkg::FLAG_D] = 1'b1;
                    end else if (lc == tlsp_pkg::CH_B) begin
                        n_flags[tlsp_pkg::FLAG_BOLD] = 1'b1;
                    end else if (lc == tlsp_pkg::CH_I) begin
                        n_flags[tlsp_pkg::FLAG_ITALIC] = 1'b1;
                    end else if (lc == tlsp_pkg::CH_F) begin
                        n_phase = PH_FONT;
                    end else begin
                        e_present = 1'b1;
                        e_valid   = 1'b1;
                        e_kind    = n_kind;
                        e_spacing = n_spacing;
                        e_flags   = n_flags;
                        e_row     = n_row;
                        e_col     = n_cell_col;
                        e_err     = tlsp_pkg::ERR_MODIFIER;
                        e_epos    = r_pos;
                        n_aborted = 1'b1;
                        n_phase   = PH_SKIP;
                    end
                end

                if (run_skip) begin
                    if (c == tlsp_pkg::CH_NUL || tlsp_pkg::is_blank(c)) begin
                        n_phase = PH_SKIP;
                    end else if (c == tlsp_pkg::CH_PERIOD) begin
                        // end of layout, with or without a cell closed by it
                        n_done = 1'b1;
                        if (!e_present) begin
                            e_present = 1'b1;
                            e_row     = n_row;
                            e_col     = n_col;
                        end
                        e_done = 1'b1;
                    end else if (c == tlsp_pkg::CH_COMMA) begin
                        if (n_have_row && n_row != '1) begin
                            n_row = n_row + 1'b1;
                        end
                        n_have_row = 1'b1;
                        n_col      = '0;
                        n_prev_bar = 1'b0;
                    end else if (!key.hit) begin
                        e_present = 1'b1;
                        e_row     = n_row;
                        e_col     = n_col;
                        e_err     = tlsp_pkg::ERR_KEY;
                        e_epos    = r_pos;
                        n_aborted = 1'b1;
                        n_phase   = PH_SKIP;
                    end else if (key.kind == tlsp_pkg::KIND_VERT) begin
                        n_bar_pos = r_pos;
                        n_phase   = PH_BAR;
                    end else begin
                        n_kind     = key.kind;
                        n_flags    = '0;
                        n_spacing  = '0;
                        n_dcount   = '0;
                        n_dval     = '0;
                        n_cell_col = n_col;
                        if (n_col != '1) begin
                            n_col = n_col + 1'b1;
                        end
                        n_prev_bar = 1'b0;
                        n_phase    = PH_MODS;
                    end
                end

                // zero byte ends the line, anything else advances the position
                if (c == tlsp_pkg::CH_NUL) begin
                    n_at_start = 1'b1;
                    n_aborted  = 1'b0;
                    n_pos      = '0;
                    n_phase    = PH_SKIP;
                    n_dcount   = '0;
                    n_dval     = '0;
                end else if (r_pos != '1) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_phase    <= PH_SKIP;
            r_kind     <= '0;
            r_flags    <= '0;
            r_spacing  <= '0;
            r_dcount   <= '0;
            r_dval     <= '0;
            r_dstart   <= '0;
            r_prev_bar <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_cell_col <= '0;
            r_pos      <= '0;
            r_bar_pos  <= '0;
            r_aborted  <= 1'b0;
            r_done     <= 1'b0;
            r_at_start <= 1'b1;
            r_have_row <= 1'b0;
        end else begin
            // input stage
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
                r_ch     <= i_s_tdata;
            end

            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_flags    <= n_flags;
            r_spacing  <= n_spacing;
            r_dcount   <= n_dcount;
            r_dval     <= n_dval;
            r_dstart   <= n_dstart;
            r_prev_bar <= n_prev_bar;
            r_row      <= n_row;
            r_col      <= n_col;
            r_cell_col <= n_cell_col;
            r_pos      <= n_pos;
            r_bar_pos  <= n_bar_pos;
            r_aborted  <= n_aborted;
            r_done     <= n_done;
            r_at_start <= n_at_start;
            r_have_row <= n_have_row;

            // output register
            if (w_adv && e_present) begin
                r_out_vld   <= 1'b1;
                r_o_valid   <= e_valid;
                r_o_kind    <= e_kind;
                r_o_spacing <= e_spacing;
                r_o_flags   <= e_flags;
                r_o_row     <= e_row;
                r_o_col     <= e_col;
                r_o_err     <= e_err;
                r_o_epos    <= e_epos;
                r_o_done    <= e_done;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0, r_o_epos, r_o_err, r_o_col, r_o_row,
                         r_o_flags, r_o_spacing, r_o_kind};
    assign o_m_tuser  = r_o_valid;
    assign o_m_tlast  = r_o_done;

endmodule

FILE: tb/table_layout_spec_parser_tb.sv
`timescale 1ns / 1ps

// where the parser model is within a layout line
typedef enum {
    SCAN_BLANK,
    SCAN_BAR,
    SCAN_MODS,
    SCAN_DIGITS,
    SCAN_FONT
} t_scan_phase;

// one record as it should leave the parser
typedef struct packed {
    logic                           valid;
    logic [tlsp_pkg::KIND_W-1:0]    kind;
    logic [tlsp_pkg::SPACING_W-1:0] spacing;
    logic [tlsp_pkg::FLAGS_W-1:0]   flags;
    logic [tlsp_pkg::ROW_W-1:0]     row;
    logic [tlsp_pkg::COL_W-1:0]     col;
    logic [tlsp_pkg::ERR_W-1:0]     err;
    logic [tlsp_pkg::POS_W-1:0]     epos;
    logic                           done;
} t_cell_rec;

// layout parser model plus the queue of records still owed by the block
class cell_record_board;
    t_scan_phase                    phase;
    logic [tlsp_pkg::KIND_W-1:0]    kind;
    logic [tlsp_pkg::FLAGS_W-1:0]   flags;
    logic [tlsp_pkg::SPACING_W-1:0] spacing;
    int                             digit_count;
    int                             digit_value;
    int                             max_digits;
    logic [tlsp_pkg::POS_W-1:0]     digit_start;
    logic [tlsp_pkg::POS_W-1:0]     bar_pos;
    logic [tlsp_pkg::POS_W-1:0]     char_pos;
    logic                           spacer_prev;
    logic [tlsp_pkg::ROW_W-1:0]     row;
    logic [tlsp_pkg::COL_W-1:0]     col;
    logic [tlsp_pkg::COL_W-1:0]     cell_col;
    logic                           aborted;
    logic                           finished;
    logic                           line_start;
    logic                           have_row;
    t_cell_rec                      rec;
    logic                           rec_ready;
    t_cell_rec                      pending[$];
    int                             errors;
    int                             checked;
    int                             cells;
    int                             faults;

    function new(int digits);
        max_digits  = digits;
        phase       = SCAN_BLANK;
        kind        = '0;
        flags       = '0;
        spacing     = '0;
        digit_count = 0;
        digit_value = 0;
        digit_start = '0;
        bar_pos     = '0;
        char_pos    = '0;
        spacer_prev = 1'b0;
        row         = '0;
        col         = '0;
        cell_col    = '0;
        aborted     = 1'b0;
        finished    = 1'b0;
        line_start  = 1'b1;
        have_row    = 1'b0;
        rec         = '0;
        rec_ready   = 1'b0;
        errors      = 0;
        checked     = 0;
        cells       = 0;
        faults      = 0;
    endfunction

    function void open_row();
        if (have_row && row != '1) begin
            row++;
        end
        have_row    = 1'b1;
        col         = '0;
        spacer_prev = 1'b0;
    endfunction

    function void open_cell(logic [tlsp_pkg::KIND_W-1:0] k);
        kind        = k;
        flags       = '0;
        spacing     = '0;
        digit_count = 0;
        digit_value = 0;
        cell_col    = col;
        if (col != '1) begin
            col++;
        end
        spacer_prev = (k == tlsp_pkg::KIND_VERT || k == tlsp_pkg::KIND_DVERT);
        phase       = SCAN_MODS;
    endfunction

    function void emit_cell(logic [tlsp_pkg::ERR_W-1:0] err, logic [tlsp_pkg::POS_W-1:0] epos);
        rec         = '0;
        rec.valid   = 1'b1;
        rec.kind    = kind;
        rec.spacing = spacing;
        rec.flags   = flags;
        rec.row     = row;
        rec.col     = cell_col;
        rec.err     = err;
        rec.epos    = epos;
        rec_ready   = 1'b1;
    endfunction

    // record with no cell: reports the next free column
    function void emit_blank(logic [tlsp_pkg::ERR_W-1:0] err, logic [tlsp_pkg::POS_W-1:0] epos);
        rec       = '0;
        rec.row   = row;
        rec.col   = col;
        rec.err   = err;
        rec.epos  = epos;
        rec_ready = 1'b1;
    endfunction

    function void abort_line();
        aborted = 1'b1;
        phase   = SCAN_BLANK;
    endfunction

    function void end_line();
        line_start  = 1'b1;
        aborted     = 1'b0;
        char_pos    = '0;
        phase       = SCAN_BLANK;
        digit_count = 0;
        digit_value = 0;
    endfunction

    function void bump_pos();
        if (char_pos != '1) begin
            char_pos++;
        end
    endfunction

    function logic [tlsp_pkg::KIND_W-1:0] key_kind(logic [7:0] lc, output logic hit);
        hit = 1'b1;
        case (lc)
            tlsp_pkg::CH_C:     return tlsp_pkg::KIND_CENTRE;
            tlsp_pkg::CH_R:     return tlsp_pkg::KIND_RIGHT;
            tlsp_pkg::CH_L:     return tlsp_pkg::KIND_LEFT;
            tlsp_pkg::CH_N:     return tlsp_pkg::KIND_NUMBER;
            tlsp_pkg::CH_S:     return tlsp_pkg::KIND_SPAN;
            tlsp_pkg::CH_A:     return tlsp_pkg::KIND_LONG;
            tlsp_pkg::CH_CARET: return tlsp_pkg::KIND_DOWN;
            tlsp_pkg::CH_MINUS: return tlsp_pkg::KIND_HORIZ;
            tlsp_pkg::CH_UNDER: return tlsp_pkg::KIND_HORIZ;
            tlsp_pkg::CH_EQUAL: return tlsp_pkg::KIND_DHORIZ;
            tlsp_pkg::CH_BAR:   return tlsp_pkg::KIND_VERT;
            default:            hit = 1'b0;
        endcase
        return tlsp_pkg::KIND_CENTRE;
    endfunction

    // advance the model by one accepted character, queue any record it owes
    function void parse_char(logic [7:0] c);
        logic [7:0]                  lc;
        logic [tlsp_pkg::POS_W-1:0]  pos;
        logic [tlsp_pkg::KIND_W-1:0] k;
        logic                        hit;
        logic                        again;
        logic                        dbl;
        if (finished) begin
            return;
        end
        if (aborted) begin
            if (c == tlsp_pkg::CH_NUL) begin
                end_line();
            end else begin
                bump_pos();
            end
            return;
        end
        rec       = '0;
        rec_ready = 1'b0;
        if (line_start) begin
            open_row();
            line_start = 1'b0;
        end
        lc  = (c >= tlsp_pkg::CH_UP_A && c <= tlsp_pkg::CH_UP_Z) ? c + tlsp_pkg::CH_CASE : c;
        pos = char_pos;
        do begin
            again = 1'b0;
            case (phase)
                SCAN_BLANK: begin
                    if (c == tlsp_pkg::CH_NUL || c == tlsp_pkg::CH_SPACE ||
                        (c >= tlsp_pkg::CH_TAB && c <= tlsp_pkg::CH_CR)) begin
                        // blanks between cells
                    end else if (c == tlsp_pkg::CH_PERIOD) begin
                        finished = 1'b1;
                        if (!rec_ready) begin
                            emit_blank(tlsp_pkg::ERR_NONE, '0);
                        end
                        rec.done = 1'b1;
                    end else if (c == tlsp_pkg::CH_COMMA) begin
                        open_row();
                    end else begin
                        k = key_kind(lc, hit);
                        if (!hit) begin
                            emit_blank(tlsp_pkg::ERR_KEY, pos);
                            abort_line();
                        end else if (k == tlsp_pkg::KIND_VERT) begin
                            bar_pos = pos;
                            phase   = SCAN_BAR;
                        end else begin
                            open_cell(k);
                        end
                    end
                end
                SCAN_BAR: begin
                    dbl = (c == tlsp_pkg::CH_BAR);
                    if (spacer_prev) begin
                        emit_blank(tlsp_pkg::ERR_SPACERS, dbl ? pos : bar_pos);
                        abort_line();
                    end else begin
                        open_cell(dbl ? tlsp_pkg::KIND_DVERT : tlsp_pkg::KIND_VERT);
                        // a single bar leaves this character for the cell body
                        again = !dbl;
                    end
                end
                SCAN_MODS: begin
                    if (c == tlsp_pkg::CH_NUL || c == tlsp_pkg::CH_SPACE ||
                        c == tlsp_pkg::CH_TAB || c == tlsp_pkg::CH_COMMA ||
                        c == tlsp_pkg::CH_PERIOD) begin
                        emit_cell(tlsp_pkg::ERR_NONE, '0);
                        phase = SCAN_BLANK;
                        again = 1'b1;
                    end else if (c >= tlsp_pkg::CH_DIG0 && c <= tlsp_pkg::CH_DIG9) begin
                        digit_start = pos;
                        digit_count = 1;
                        digit_value = int'(c - tlsp_pkg::CH_DIG0);
                        phase       = SCAN_DIGITS;
                    end else begin
                        case (lc)
                            tlsp_pkg::CH_Z: flags[tlsp_pkg::FLAG_Z]      = 1'b1;
                            tlsp_pkg::CH_U: flags[tlsp_pkg::FLAG_U]      = 1'b1;
                            tlsp_pkg::CH_E: flags[tlsp_pkg::FLAG_E]      = 1'b1;
                            tlsp_pkg::CH_T: flags[tlsp_pkg::FLAG_T]      = 1'b1;
                            tlsp_pkg::CH_D: flags[tlsp_pkg::FLAG_D]      = 1'b1;
                            tlsp_pkg::CH_B: flags[tlsp_pkg::FLAG_BOLD]   = 1'b1;
                            tlsp_pkg::CH_I: flags[tlsp_pkg::FLAG_ITALIC] = 1'b1;
                            tlsp_pkg::CH_F: phase = SCAN_FONT;
                            default: begin
                                emit_cell(tlsp_pkg::ERR_MODIFIER, pos);
                                abort_line();
                            end
                        endcase
                    end
                end
                SCAN_DIGITS: begin
                    if (c >= tlsp_pkg::CH_DIG0 && c <= tlsp_pkg::CH_DIG9) begin
                        digit_count++;
                        digit_value = digit_value * 10 + int'(c - tlsp_pkg::CH_DIG0);
                        // too long: cell keeps its previous spacing
                        if (digit_count > max_digits) begin
                            emit_cell(tlsp_pkg::ERR_SPACING, digit_start);
                            abort_line();
                        end
                    end else begin
                        spacing = (digit_value > int'(tlsp_pkg::SPACING_MAX)) ?
                                  tlsp_pkg::SPACING_MAX :
                                  digit_value[tlsp_pkg::SPACING_W-1:0];
                        digit_count = 0;
                        digit_value = 0;
                        phase       = SCAN_MODS;
                        again       = 1'b1;
                    end
                end
                default: begin
                    if (lc == tlsp_pkg::CH_B) begin
                        flags[tlsp_pkg::FLAG_BOLD] = 1'b1;
                        phase = SCAN_MODS;
                    end else if (lc == tlsp_pkg::CH_I) begin
                        flags[tlsp_pkg::FLAG_ITALIC] = 1'b1;
                        phase = SCAN_MODS;
                    end else begin
                        emit_cell(tlsp_pkg::ERR_FONT, pos);
                        abort_line();
                    end
                end
            endcase
        end while (again);
        if (c == tlsp_pkg::CH_NUL) begin
            end_line();
        end else begin
            bump_pos();
        end
        if (rec_ready) begin
            pending.push_back(rec);
        end
    endfunction

    task report(string what);
        errors++;
        $display("[%0t] mismatch %0d: %s", $time, errors, what);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0d, expected %0d (record %0d)", name, got, want,
                             checked));
        end
    endtask

    task check_record(logic [55:0] data, logic cell_flag, logic done_flag);
        t_cell_rec want;
        if (pending.size() == 0) begin
            report($sformatf("record with nothing pending, tdata %h", data));
            return;
        end
        want = pending.pop_front();
        compare_field("cell_valid", 16'(cell_flag), 16'(want.valid));
        compare_field("cell_kind", 16'(data[3:0]), 16'(want.kind));
        compare_field("spacing", 16'(data[13:4]), 16'(want.spacing));
        compare_field("modifier_flags", 16'(data[20:14]), 16'(want.flags));
        compare_field("row_index", 16'(data[28:21]), 16'(want.row));
        compare_field("column_index", 16'(data[36:29]), 16'(want.col));
        compare_field("error_code", 16'(data[39:37]), 16'(want.err));
        compare_field("error_position", 16'(data[51:40]), 16'(want.epos));
        compare_field("tdata padding", 16'(data[55:52]), 16'd0);
        compare_field("layout_done", 16'(done_flag), 16'(want.done));
        checked++;
        if (want.valid) begin
            cells++;
        end
        if (want.err != tlsp_pkg::ERR_NONE) begin
            faults++;
        end
    endtask
endclass

module table_layout_spec_parser_tb;

    localparam int SPACING_DIGITS = 3;
    localparam int STALL_LIMIT    = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic        m_valid;
    logic        m_ready;
    logic [55:0] m_data;
    logic        m_user;
    logic        m_last;

    cell_record_board board;
    int in_calm;
    int out_calm;
    int chars_sent;
    int lines_sent;

    table_layout_spec_parser #(
        .MAX_SPACING_DIGITS(SPACING_DIGITS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user),
        .o_m_tlast  (m_last)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle cycles before the next beat; now and then a run of back-to-back beats
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        // a period would end the layout for good
        do b = 8'($urandom_range(0, 255)); while (b == tlsp_pkg::CH_PERIOD);
        return b;
    endfunction

    function automatic logic [7:0] any_case(logic [7:0] c);
        if (c >= tlsp_pkg::CH_A && c <= tlsp_pkg::CH_Z && $urandom_range(0, 1) == 1) begin
            return c - tlsp_pkg::CH_CASE;
        end
        return c;
    endfunction

    function automatic logic [7:0] mod_letter();
        string m;
        m = "zuetdbi";
        return any_case(m[$urandom_range(0, 6)]);
    endfunction

    // entered and left at a falling edge
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = draw_wait(in_calm);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid = 1'b1;
        s_data  = c;
        do @(posedge clk); while (s_ready !== 1'b1);
        board.parse_char(c);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
        send_char(tlsp_pkg::CH_NUL);
        lines_sent++;
    endtask

    // occasionally swaps a character for a stray byte
    task automatic send_text(input logic [7:0] c);
        if ($urandom_range(0, 39) == 0) begin
            send_char(noise_byte());
        end else begin
            send_char(c);
        end
    endtask

    task automatic send_random_line();
        string keys;
        int    k;
        int    ndig;
        keys = "crlnsa^-_=|";
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) send_char(noise_byte());
            send_char(tlsp_pkg::CH_NUL);
            lines_sent++;
            return;
        end
        if ($urandom_range(0, 5) == 0) begin
            send_text(tlsp_pkg::CH_SPACE);
        end
        for (int j = 0; j < $urandom_range(1, 6); j++) begin
            if (j > 0) begin
                case ($urandom_range(0, 5))
                    0: send_text(tlsp_pkg::CH_TAB);
                    1: send_text(tlsp_pkg::CH_COMMA);
                    2: begin
                        send_text(tlsp_pkg::CH_SPACE);
                        send_text(tlsp_pkg::CH_SPACE);
                    end
                    default: send_text(tlsp_pkg::CH_SPACE);
                endcase
            end
            k = $urandom_range(0, 11);
            if (k == 11) begin
                send_text(tlsp_pkg::CH_BAR);
                send_text(tlsp_pkg::CH_BAR);
            end else begin
                send_text(any_case(keys[k]));
            end
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 4))
                    0, 1: send_text(mod_letter());
                    2: begin
                        ndig = ($urandom_range(0, 15) == 0) ? 4 : $urandom_range(1, 3);
                        repeat (ndig) begin
                            send_text(tlsp_pkg::CH_DIG0 + 8'($urandom_range(0, 9)));
                        end
                    end
                    3: begin
                        send_text(any_case(tlsp_pkg::CH_F));
                        if ($urandom_range(0, 19) == 0) begin
                            send_char(noise_byte());
                        end else begin
                            send_text(any_case($urandom_range(0, 1) ?
                                               tlsp_pkg::CH_B : tlsp_pkg::CH_I));
                        end
                    end
                    default: send_text(any_case($urandom_range(0, 1) ?
                                                tlsp_pkg::CH_B : tlsp_pkg::CH_I));
                endcase
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            send_text(tlsp_pkg::CH_SPACE);
        end
        send_char(tlsp_pkg::CH_NUL);
        lines_sent++;
    endtask

    // record side: random stalls, check on every handshake
    initial begin
        int n;
        m_ready  = 1'b0;
        out_calm = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            n = draw_wait(out_calm);
            if (n > 0) begin
                m_ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_ready = 1'b1;
            do @(posedge clk); while (m_valid !== 1'b1);
            board.check_record(m_data, m_user, m_last);
            @(negedge clk);
        end
    end

    // ends the run when no beat moves on either side for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_valid === 1'b1 && m_ready === 1'b1)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("table_layout_spec_parser_tb: FAIL");
        $finish;
    end

    initial begin
        int random_start;
        board      = new(SPACING_DIGITS);
        in_calm    = 0;
        chars_sent = 0;
        lines_sent = 0;
        rst_n      = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every key, both cases
        send_line("c r l n s a ^ - _ = | C R L N S A");
        // flags, spacing extremes, fonts direct and after f, then a bad font
        send_line("cz1ue999tdbi lfbFI3 r0 nfx");
        // double bar, comma row break, adjacent spacers
        send_line("|| c |,| | s");
        send_line("|| ||");
        send_line("");
        send_line("r12345");
        send_line("lB7q");
        send_line("cU\n");
        send_line("a^2,,s");
        // the blank codes from tab to carriage return before the first cell, then a bad key
        for (int b = tlsp_pkg::CH_TAB; b <= tlsp_pkg::CH_CR; b++) begin
            send_char(8'(b));
        end
        send_line("= _z x");

        // column counter runs into saturation
        repeat (260) begin
            send_char(tlsp_pkg::CH_C);
            send_char(tlsp_pkg::CH_SPACE);
        end
        send_line("x");

        random_start = chars_sent;
        while (chars_sent - random_start < 580) begin
            send_random_line();
        end

        // row counter saturation through bare commas, then the layout ends
        repeat (260) send_char(tlsp_pkg::CH_COMMA);
        if ($urandom_range(0, 1) == 1) begin
            send_line("lb.");
        end else begin
            send_line(" .");
        end
        // everything after the period is dropped
        repeat (30) send_char(8'($urandom_range(0, 255)));
        send_char(tlsp_pkg::CH_PERIOD);
        send_char(tlsp_pkg::CH_NUL);
        s_valid = 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.pending.size() != 0) begin
            board.report($sformatf("%0d records never arrived", board.pending.size()));
        end

        $display("run covered %0d characters over %0d lines, %0d records checked",
                 chars_sent, lines_sent, board.checked);
        $display("  of those %0d carried a cell and %0d an error", board.cells, board.faults);
        if (board.errors == 0) begin
            $display("table_layout_spec_parser_tb: PASS");
        end else begin
            $display("table_layout_spec_parser_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tlsp_pkg.sv
hw/rtl/table_layout_spec_parser.sv
tb/table_layout_spec_parser_tb.sv
